@@ sv/integer_to_radix_ascii_defines.svh @@
// Assertion helpers for the file that checks its own logic.
`ifndef INTEGER_TO_RADIX_ASCII_DEFINES_SVH
`define INTEGER_TO_RADIX_ASCII_DEFINES_SVH

// Check a property at every rising clock edge outside reset.
`define ITRA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next.
`define ITRA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/itra_pkg.sv @@
package itra_pkg;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 8;

   // request field positions inside req_tdata
   localparam int REQ_MODE_LSB  = 0;
   localparam int REQ_VALUE_LSB = 1;
   localparam int REQ_RADIX_LSB = 33;
   localparam int REQ_CAP_LSB   = 39;

   localparam logic       MODE_SIGNED = 1'b0;
   localparam logic [5:0] RADIX_MIN   = 6'd2;
   localparam logic [5:0] RADIX_MAX   = 6'd36;
   localparam logic [5:0] RADIX_DEC   = 6'd10;
   localparam logic [5:0] DIGIT_TEN   = 6'd10;

   localparam logic [7:0] CHAR_ZERO        = 8'h30;
   localparam logic [7:0] CHAR_NINE        = 8'h39;
   localparam logic [7:0] CHAR_A           = 8'h41;
   localparam logic [7:0] CHAR_Z           = 8'h5A;
   localparam logic [7:0] CHAR_LETTER_BASE = 8'h37;  // 'A' minus ten
   localparam logic [7:0] CHAR_MINUS       = 8'h2D;
   localparam logic [7:0] CHAR_NONE        = 8'h00;

   typedef struct packed {
      logic       err;       // bad radix or zero capacity
      logic       sign_req;  // negative decimal, sign wanted if room remains
      logic [5:0] radix;
      logic [6:0] cap_m1;    // capacity minus one
   } cmd_ctl_type;

   typedef struct packed {
      logic empty;
      logic full;
   } fifo_stat_type;

   typedef struct packed {
      logic idle;
   } back_stat_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_DIV,
      B_SIGN,
      B_READ,
      B_LOAD,
      B_ERR
   } back_state_type;

   function automatic logic [7:0] digit_char(input logic [5:0] d);
      if (d < DIGIT_TEN) begin
         return CHAR_ZERO + {2'b00, d};
      end
      return CHAR_LETTER_BASE + {2'b00, d};
   endfunction

endpackage

@@ sv/itra_fifo.sv @@
module itra_fifo #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  logic [WIDTH-1:0]        push_data,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output logic [WIDTH-1:0]        pop_data,
   output itra_pkg::fifo_stat_type stat
);
   import itra_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign stat.empty = !pop_valid;
   assign stat.full  = !push_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ sv/itra_front.sv @@
module itra_front #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [itra_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                cmd_valid,
   input  logic                                cmd_ready,
   output itra_pkg::cmd_ctl_type               cmd_ctl,
   output logic [VALUE_WIDTH-1:0]              cmd_mag
);
   import itra_pkg::*;

   logic                   mode;
   logic [31:0]            value;
   logic [5:0]             radix;
   logic [6:0]             capacity;
   logic [VALUE_WIDTH+31:0] value_ext;
   logic [VALUE_WIDTH-1:0] value_w;
   logic                   neg;

   logic                   valid_ff, valid_in;
   cmd_ctl_type            ctl_ff, ctl_in;
   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic                   take;

   assign mode     = req_tdata[REQ_MODE_LSB];
   assign value    = req_tdata[REQ_VALUE_LSB +: 32];
   assign radix    = req_tdata[REQ_RADIX_LSB +: 6];
   assign capacity = req_tdata[REQ_CAP_LSB +: 7];

   // keep only the low VALUE_WIDTH bits, zero-extend when wider
   assign value_ext = {{VALUE_WIDTH{1'b0}}, value};
   assign value_w   = value_ext[VALUE_WIDTH-1:0];

   assign req_tready = !valid_ff || cmd_ready;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      neg             = (mode == MODE_SIGNED) && value_w[VALUE_WIDTH-1];
      ctl_in.err      = (radix < RADIX_MIN) || (radix > RADIX_MAX) || (capacity == 7'd0);
      ctl_in.sign_req = neg && (radix == RADIX_DEC);
      ctl_in.radix    = radix;
      ctl_in.cap_m1   = capacity - 7'd1;
      mag_in          = neg ? (~value_w + 1'b1) : value_w;
      valid_in        = take ? 1'b1 : (cmd_ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         ctl_ff <= ctl_in;
         mag_ff <= mag_in;
      end
   end

   assign cmd_valid = valid_ff;
   assign cmd_ctl   = ctl_ff;
   assign cmd_mag   = mag_ff;

endmodule

@@ sv/itra_back.sv @@
module itra_back #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               cmd_valid,
   output logic                               cmd_ready,
   input  itra_pkg::cmd_ctl_type              cmd_ctl,
   input  logic [VALUE_WIDTH-1:0]             cmd_mag,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [itra_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tlast,
   output logic [0:0]                         rsp_tuser,
   output itra_pkg::back_stat_type            stat
);
   import itra_pkg::*;

   localparam int BW = $clog2(VALUE_WIDTH);
   localparam int IW = $clog2(VALUE_WIDTH);
   localparam int CW = $clog2(VALUE_WIDTH + 1);

   back_state_type         state_ff, state_in;
   logic [VALUE_WIDTH-1:0] q_ff, q_in;
   logic [5:0]             rem_ff, rem_in;
   logic [BW-1:0]          bit_ff, bit_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [5:0]             radix_ff, radix_in;
   logic [6:0]             capm1_ff, capm1_in;
   logic                   srq_ff, srq_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_char_ff, rsp_char_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   rsp_err_ff, rsp_err_in;
   logic                   load, out_free;

   logic [5:0]             digit_mem [VALUE_WIDTH];
   logic [5:0]             rd_data_ff;
   logic                   we, re;
   logic [IW-1:0]          waddr, raddr;
   logic [5:0]             wdata;

   logic [6:0]             trial, diff;
   logic                   ge;
   logic [5:0]             rem_new;
   logic [VALUE_WIDTH-1:0] q_new;
   logic [CW-1:0]          count_inc, count_dec;
   logic [7:0]             limit8;
   logic                   more, sign_ok;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign stat.idle = (state_ff == B_IDLE);

   // one restoring division step on the running quotient
   always_comb begin
      trial     = {rem_ff, q_ff[VALUE_WIDTH-1]};
      diff      = trial - {1'b0, radix_ff};
      ge        = (trial >= {1'b0, radix_ff});
      rem_new   = ge ? diff[5:0] : trial[5:0];
      q_new     = {q_ff[VALUE_WIDTH-2:0], ge};
      count_inc = count_ff + 1'b1;
      count_dec = count_ff - 1'b1;
      limit8    = (capm1_ff == 7'd0) ? 8'd1 : {1'b0, capm1_ff};
      more      = (q_new != '0) && (8'(count_inc) < limit8)
                  && (count_inc < CW'(VALUE_WIDTH));
      sign_ok   = srq_ff && (q_new == '0) && ((8'(count_inc) + 8'd1) <= {1'b0, capm1_ff});
   end

   always_comb begin
      state_in    = state_ff;
      q_in        = q_ff;
      rem_in      = rem_ff;
      bit_in      = bit_ff;
      count_in    = count_ff;
      radix_in    = radix_ff;
      capm1_in    = capm1_ff;
      srq_in      = srq_ff;
      cmd_ready   = 1'b0;
      we          = 1'b0;
      waddr       = count_ff[IW-1:0];
      wdata       = rem_new;
      re          = 1'b0;
      raddr       = count_dec[IW-1:0];
      load        = 1'b0;
      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;
      rsp_err_in  = rsp_err_ff;

      unique case (state_ff)
         B_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               radix_in = cmd_ctl.radix;
               capm1_in = cmd_ctl.cap_m1;
               srq_in   = cmd_ctl.sign_req;
               q_in     = cmd_mag;
               rem_in   = '0;
               bit_in   = '0;
               count_in = '0;
               state_in = cmd_ctl.err ? B_ERR : B_DIV;
            end
         end
         B_DIV: begin
            q_in = q_new;
            if (bit_ff == BW'(VALUE_WIDTH - 1)) begin
               // digit done: store it, then divide again or start output
               we       = 1'b1;
               count_in = count_inc;
               rem_in   = '0;
               bit_in   = '0;
               if (more) begin
                  state_in = B_DIV;
               end else begin
                  srq_in   = sign_ok;
                  state_in = sign_ok ? B_SIGN : B_READ;
               end
            end else begin
               rem_in = rem_new;
               bit_in = bit_ff + 1'b1;
            end
         end
         B_SIGN: begin
            if (out_free) begin
               load        = 1'b1;
               rsp_char_in = CHAR_MINUS;
               rsp_last_in = 1'b0;
               rsp_err_in  = 1'b0;
               state_in    = B_READ;
            end
         end
         B_READ: begin
            re       = 1'b1;
            state_in = B_LOAD;
         end
         B_LOAD: begin
            if (out_free) begin
               load        = 1'b1;
               rsp_char_in = digit_char(rd_data_ff);
               rsp_last_in = (count_ff == CW'(1));
               rsp_err_in  = 1'b0;
               count_in    = count_dec;
               state_in    = (count_ff == CW'(1)) ? B_IDLE : B_READ;
            end
         end
         B_ERR: begin
            if (out_free) begin
               load        = 1'b1;
               rsp_char_in = CHAR_NONE;
               rsp_last_in = 1'b1;
               rsp_err_in  = 1'b1;
               state_in    = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase

      rsp_valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff     <= q_in;
      rem_ff   <= rem_in;
      bit_ff   <= bit_in;
      count_ff <= count_in;
      radix_ff <= radix_in;
      capm1_ff <= capm1_in;
      srq_ff   <= srq_in;
      if (load) begin
         rsp_char_ff <= rsp_char_in;
         rsp_last_ff <= rsp_last_in;
         rsp_err_ff  <= rsp_err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         digit_mem[waddr] <= wdata;
      end
      if (re) begin
         rd_data_ff <= digit_mem[raddr];
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_char_ff;
   assign rsp_tlast    = rsp_last_ff;
   assign rsp_tuser[0] = rsp_err_ff;

endmodule

@@ sv/integer_to_radix_ascii.sv @@
// Integer to ASCII string converter, radix 2 to 36.
// Request channel (req_*): one beat per conversion carrying mode, value, radix and
// capacity. Response channel (rsp_*): one beat per character, most significant
// first, '-' first for a negative decimal value when room remains; tlast marks the final character.
// A bad radix or zero capacity gives a single beat with tuser set, data zero, tlast.
// A front stage checks and classifies the request and forms the magnitude; a
// two-entry command queue lets it take the next request while the back end works.
// The back end divides bit-serially: each digit takes a restoring subtract step for
// each of the VALUE_WIDTH quotient bits and is written into a small digit memory.
// Output then reads the memory back, a registered read and then a load per character.
// Reset (synchronous, active high) empties the queue and all beat registers;
// the digit memory needs no clearing, it is always written before it is read.
// A stall on rsp_tready holds the output beat and parks the back end at its next
// beat; the queue and front register then fill and req_tready drops after three
// more requests.
`include "integer_to_radix_ascii_defines.svh"

module integer_to_radix_ascii #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [0] mode, [32:1] value, [38:33] radix, [45:39] capacity, [47:46] zero
   input  logic [itra_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [7:0] char_code
   output logic [itra_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast,
   // [0] error
   output logic [0:0]                      rsp_tuser
);
   import itra_pkg::*;

   localparam int QW = $bits(cmd_ctl_type) + VALUE_WIDTH;

   // front to queue
   logic                   f_valid, f_ready;
   cmd_ctl_type            f_ctl;
   logic [VALUE_WIDTH-1:0] f_mag;

   // queue to back
   logic                   b_valid, b_ready;
   logic [QW-1:0]          b_data;
   cmd_ctl_type            b_ctl;
   logic [VALUE_WIDTH-1:0] b_mag;

   fifo_stat_type          q_stat;
   back_stat_type          be_stat;

   itra_front #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .cmd_valid  (f_valid),
      .cmd_ready  (f_ready),
      .cmd_ctl    (f_ctl),
      .cmd_mag    (f_mag)
   );

   itra_fifo #(
      .WIDTH(QW),
      .DEPTH(2)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  ({f_ctl, f_mag}),
      .pop_valid  (b_valid),
      .pop_ready  (b_ready),
      .pop_data   (b_data),
      .stat       (q_stat)
   );

   assign b_ctl = b_data[QW-1:VALUE_WIDTH];
   assign b_mag = b_data[VALUE_WIDTH-1:0];

   itra_back #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (b_valid),
      .cmd_ready  (b_ready),
      .cmd_ctl    (b_ctl),
      .cmd_mag    (b_mag),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .stat       (be_stat)
   );

   // an error beat is a lone, empty, final beat
   `ITRA_ASSERT(a_err_beat, clock, reset, !(rsp_tvalid && rsp_tuser[0]) || (rsp_tlast && (rsp_tdata == CHAR_NONE)), "error beat malformed")

   // the sign always leads, never ends the string
   `ITRA_ASSERT(a_sign_not_last, clock, reset, !(rsp_tvalid && !rsp_tuser[0] && (rsp_tdata == CHAR_MINUS)) || !rsp_tlast, "sign beat marked last")

   // every other normal beat is a digit or letter
   `ITRA_ASSERT(a_digit_range, clock, reset, !(rsp_tvalid && !rsp_tuser[0] && (rsp_tdata != CHAR_MINUS)) || ((rsp_tdata >= CHAR_ZERO) && (rsp_tdata <= CHAR_NINE)) || ((rsp_tdata >= CHAR_A) && (rsp_tdata <= CHAR_Z)), "character out of digit set")

   // an idle back end picks up a queued command at once
   `ITRA_ASSERT_NEXT(a_back_pickup, clock, reset, be_stat.idle && !q_stat.empty, !be_stat.idle, "queued command not taken")

endmodule
